### design/phpl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phpl_pkg - shared types and constants for the PID heater PWM loop
// Field widths, register map, controller limits and the two-digit split.
// ----------------------------------------------------------------------------
package phpl_pkg;

    // Default sensor width
    localparam int unsigned SAMPLE_BITS_DEF = 16;

    // Fixed field widths
    localparam int unsigned SETPOINT_W = 16;
    localparam int unsigned GAIN_W     = 8;
    localparam int unsigned INTEG_W    = 12;
    localparam int unsigned ACC_W      = 16;
    localparam int unsigned DUTY_W     = 8;
    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned TENK_W     = 3;
    localparam int unsigned PAIR_W     = 7;

    // APB port geometry
    localparam int unsigned APB_AW = 4;
    localparam int unsigned APB_DW = 32;

    // Controller limits (integral in half units, drive in 1/200 duty steps)
    localparam int INTEG_LIMIT = 2000;
    localparam int DRIVE_SCALE = 200;
    localparam int DRIVE_MAX   = 255 * DRIVE_SCALE;

    // Decimal split constants
    localparam int DIV_TEN      = 10;
    localparam int DIV_PAIR     = 100;
    localparam int DIV_THOUSAND = 1000;
    localparam int DIGIT_MAX    = 9;

    // floor(v / 10) == (v * 103) >> 10 for every v below 100
    localparam int unsigned TENTH_RECIP = 103;
    localparam int unsigned TENTH_SHIFT = 10;

    // Register reset values
    localparam logic [SETPOINT_W-1:0] RST_SETPOINT = '0;
    localparam logic [GAIN_W-1:0]     RST_GAIN_P   = 8'd5;
    localparam logic [GAIN_W-1:0]     RST_GAIN_I   = 8'd1;
    localparam logic [GAIN_W-1:0]     RST_GAIN_D   = 8'd1;

    // Register map, word index = paddr[3:2]
    typedef enum logic [1:0] {
        REG_SETPOINT,
        REG_GAIN_P,
        REG_GAIN_I,
        REG_GAIN_D
    } t_reg_idx;

    typedef struct packed {
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] ones;
    } t_digit_pair;

    // Split a value 0..99 into its tens and ones digits
    function automatic t_digit_pair f_split_pair(input logic [PAIR_W-1:0] v);
        logic [PAIR_W+TENTH_SHIFT-1:0] prod;
        logic [PAIR_W-1:0]             rem;
        t_digit_pair                   res;
        prod     = (PAIR_W+TENTH_SHIFT)'(v) * (PAIR_W+TENTH_SHIFT)'(TENTH_RECIP);
        res.tens = prod[TENTH_SHIFT +: DIGIT_W];
        rem      = v - PAIR_W'(res.tens) * PAIR_W'(DIV_TEN);
        res.ones = rem[DIGIT_W-1:0];
        return res;
    endfunction

endpackage

### design/pid_heater_pwm_loop.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_heater_pwm_loop - incremental PID heater controller with PWM drive
// Error, trapezoidal integral and derivative feed a clamped drive accumulator;
// the sample is also split into five decimal digits for display.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel : i_valid / o_stall carry one sample word (i_sample).
//   Output channel: o_valid / i_stall carry one result word per sample:
//                   o_duty and the five decimal digits of that sample.
//   Config        : APB registers at 0x0 setpoint, 0x4 kp/10, 0x8 ki/100,
//                   0xC kd/10. Writing the setpoint clears the integral.
//                   Write registers only while no sample is in flight.
// Timing:
//   Four register stages (input, PID, divide, output). An accepted sample
//   moves through them in that order. One word is taken every cycle while
//   nothing stalls; the controller state updates once per word in the PID
//   stage, which sets the one-word-per-cycle throughput.
// Stall:
//   While an output word waits under i_stall the whole pipeline holds and
//   o_stall is raised; o_stall is low whenever the output register is empty.
// Reset:
//   Synchronous, active low. Empties the pipeline, zeroes integral, previous
//   error and accumulator, and loads the register reset values.
// ----------------------------------------------------------------------------
module pid_heater_pwm_loop #(
    parameter int unsigned SAMPLE_BITS = phpl_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // sample channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [SAMPLE_BITS-1:0]           i_sample,
    // result channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [phpl_pkg::DUTY_W-1:0]      o_duty,
    output logic [phpl_pkg::TENK_W-1:0]      o_digit_ten_thousands,
    output logic [phpl_pkg::DIGIT_W-1:0]     o_digit_thousands,
    output logic [phpl_pkg::DIGIT_W-1:0]     o_digit_hundreds,
    output logic [phpl_pkg::DIGIT_W-1:0]     o_digit_tens,
    output logic [phpl_pkg::DIGIT_W-1:0]     o_digit_ones,
    // APB config port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [phpl_pkg::APB_AW-1:0]      paddr,
    input  logic [phpl_pkg::APB_DW-1:0]      pwdata,
    output logic [phpl_pkg::APB_DW-1:0]      prdata,
    output logic                             pready
);
    import phpl_pkg::*;

    // ------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------
    // error = setpoint - sample, signed
    localparam int unsigned EW = ((SAMPLE_BITS > SETPOINT_W) ? SAMPLE_BITS : SETPOINT_W) + 1;
    // PID sum width, wide enough for accumulator plus all three terms
    localparam int unsigned TW = EW + 16;
    localparam int unsigned GAIN20_W = GAIN_W + 5;

    // q = sample / 100 by reciprocal multiply
    localparam int unsigned Q_MAX  = ((1 << SAMPLE_BITS) - 1) / DIV_PAIR;
    localparam int unsigned QW     = (Q_MAX < 2) ? 1 : $clog2(Q_MAX + 1);
    localparam int unsigned Q_SH   = SAMPLE_BITS + 7;
    localparam logic [63:0] Q_K    = (64'd1 << Q_SH) / DIV_PAIR + 64'd1;
    localparam int unsigned Q_PW   = Q_SH + QW;

    // q2 = q / 100 = sample / 10000
    localparam int unsigned Q2_MAX = Q_MAX / DIV_PAIR;
    localparam int unsigned Q2W    = (Q2_MAX < 2) ? 1 : $clog2(Q2_MAX + 1);
    localparam int unsigned Q2_SH  = QW + 7;
    localparam logic [63:0] Q2_K   = (64'd1 << Q2_SH) / DIV_PAIR + 64'd1;
    localparam int unsigned Q2_PW  = Q2_SH + Q2W;

    // q3 = q / 1000 = sample / 100000
    localparam int unsigned Q3_MAX = Q_MAX / DIV_THOUSAND;
    localparam int unsigned Q3W    = (Q3_MAX < 2) ? 1 : $clog2(Q3_MAX + 1);
    localparam int unsigned Q3_SH  = QW + 10;
    localparam logic [63:0] Q3_K   = (64'd1 << Q3_SH) / DIV_THOUSAND + 64'd1;
    localparam int unsigned Q3_PW  = Q3_SH + Q3W;

    // duty = acc / 200; acc never exceeds 51000 so the product fits 32 bits
    localparam int unsigned DUTY_SH = ACC_W + 8;
    localparam logic [63:0] DUTY_K  = (64'd1 << DUTY_SH) / DRIVE_SCALE + 64'd1;
    localparam int unsigned DUTY_PW = DUTY_SH + DUTY_W;

    // remainder widths
    localparam int unsigned DW  = (QW > PAIR_W) ? QW : PAIR_W;
    localparam int unsigned TDW = (Q2W > DIGIT_W) ? Q2W : DIGIT_W;

    // ------------------------------------------------------------------
    // Pipeline control: global enable, held while the output word waits
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic r_a_valid;
    logic r_b_valid;
    logic r_c_valid;
    logic w_en;
    logic w_accept;
    logic w_adv_a;
    logic w_adv_b;
    logic w_adv_c;

    assign w_en     = !(r_out_valid && i_stall);
    assign w_accept = i_valid && w_en;
    assign w_adv_a  = r_a_valid && w_en;
    assign w_adv_b  = r_b_valid && w_en;
    assign w_adv_c  = r_c_valid && w_en;
    assign o_stall  = !w_en;
    assign o_valid  = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid   <= i_valid;
            r_b_valid   <= r_a_valid;
            r_c_valid   <= r_b_valid;
            r_out_valid <= r_c_valid;
        end
    end

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [SETPOINT_W-1:0] r_setpoint;
    logic [GAIN_W-1:0]     r_kp;
    logic [GAIN_W-1:0]     r_ki;
    logic [GAIN_W-1:0]     r_kd;
    logic                  w_cfg_wr;
    t_reg_idx              w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= RST_SETPOINT;
            r_kp       <= RST_GAIN_P;
            r_ki       <= RST_GAIN_I;
            r_kd       <= RST_GAIN_D;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_SETPOINT: r_setpoint <= pwdata[SETPOINT_W-1:0];
                REG_GAIN_P:   r_kp       <= pwdata[GAIN_W-1:0];
                REG_GAIN_I:   r_ki       <= pwdata[GAIN_W-1:0];
                REG_GAIN_D:   r_kd       <= pwdata[GAIN_W-1:0];
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (w_cfg_idx)
            REG_SETPOINT: prdata = APB_DW'(r_setpoint);
            REG_GAIN_P:   prdata = APB_DW'(r_kp);
            REG_GAIN_I:   prdata = APB_DW'(r_ki);
            REG_GAIN_D:   prdata = APB_DW'(r_kd);
        endcase
    end

    // ------------------------------------------------------------------
    // Stage A: input register
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] r_a_sample;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_sample <= i_sample;
        end
    end

    // ------------------------------------------------------------------
    // PID update (stage A -> B), controller state changes once per word
    // ------------------------------------------------------------------
    logic signed [EW-1:0]      r_prev_err;
    logic signed [INTEG_W-1:0] r_integ;
    logic [ACC_W-1:0]          r_acc;

    logic signed [EW-1:0]      w_err;
    logic signed [EW:0]        w_deriv;
    logic signed [EW+1:0]      w_int_sum;
    logic signed [INTEG_W-1:0] n_integ;
    logic [GAIN20_W-1:0]       w_kp20;
    logic [GAIN20_W-1:0]       w_kd20;
    logic signed [TW-1:0]      w_term_p;
    logic signed [TW-1:0]      w_term_i;
    logic signed [TW-1:0]      w_term_d;
    logic signed [TW-1:0]      w_acc_sum;
    logic [ACC_W-1:0]          n_acc;

    assign w_err     = $signed(EW'(r_setpoint)) - $signed(EW'(r_a_sample));
    assign w_deriv   = (EW+1)'(w_err) - (EW+1)'(r_prev_err);
    assign w_int_sum = (EW+2)'(r_integ) + (EW+2)'(w_err) + (EW+2)'(r_prev_err);

    // trapezoid, clamped to +-1000 units
    always_comb begin
        priority if (w_int_sum > $signed((EW+2)'(INTEG_LIMIT))) begin
            n_integ = INTEG_W'(INTEG_LIMIT);
        end else if (w_int_sum < $signed((EW+2)'(-INTEG_LIMIT))) begin
            n_integ = INTEG_W'(-INTEG_LIMIT);
        end else begin
            n_integ = w_int_sum[INTEG_W-1:0];
        end
    end

    // gain * 20 brings kp/10 and kd/10 onto the 1/200 drive scale
    assign w_kp20 = GAIN20_W'({r_kp, 4'b0000}) + GAIN20_W'({r_kp, 2'b00});
    assign w_kd20 = GAIN20_W'({r_kd, 4'b0000}) + GAIN20_W'({r_kd, 2'b00});

    assign w_term_p  = TW'(w_err) * $signed(TW'(w_kp20));
    assign w_term_i  = TW'(n_integ) * $signed(TW'(r_ki));
    assign w_term_d  = TW'(w_deriv) * $signed(TW'(w_kd20));
    assign w_acc_sum = $signed(TW'(r_acc)) + w_term_p + w_term_i + w_term_d;

    // drive clamp 0..255 duty steps
    always_comb begin
        priority if (w_acc_sum < 0) begin
            n_acc = '0;
        end else if (w_acc_sum > $signed(TW'(DRIVE_MAX))) begin
            n_acc = ACC_W'(DRIVE_MAX);
        end else begin
            n_acc = w_acc_sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
            r_integ    <= '0;
            r_acc      <= '0;
        end else begin
            if (w_adv_a) begin
                r_prev_err <= w_err;
                r_integ    <= n_integ;
                r_acc      <= n_acc;
            end
            // new setpoint restarts the integral
            if (w_cfg_wr && w_cfg_idx == REG_SETPOINT) begin
                r_integ <= '0;
            end
        end
    end

    // sample / 100 in parallel with the PID update
    logic [Q_PW-1:0] w_q_prod;

    assign w_q_prod = Q_PW'(r_a_sample) * Q_PW'(Q_K);

    // ------------------------------------------------------------------
    // Stage B
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] r_b_sample;
    logic [QW-1:0]          r_b_q;
    logic [ACC_W-1:0]       r_b_acc;

    always_ff @(posedge i_clk) begin
        if (w_adv_a) begin
            r_b_sample <= r_a_sample;
            r_b_q      <= w_q_prod[Q_SH +: QW];
            r_b_acc    <= n_acc;
        end
    end

    // low pair, /10000, /100000 and duty (stage B -> C)
    logic [SAMPLE_BITS-1:0] w_lo_full;
    logic [Q2_PW-1:0]       w_q2_prod;
    logic [Q3_PW-1:0]       w_q3_prod;
    logic [DUTY_PW-1:0]     w_duty_prod;

    assign w_lo_full   = r_b_sample - SAMPLE_BITS'(r_b_q) * SAMPLE_BITS'(DIV_PAIR);
    assign w_q2_prod   = Q2_PW'(r_b_q) * Q2_PW'(Q2_K);
    assign w_q3_prod   = Q3_PW'(r_b_q) * Q3_PW'(Q3_K);
    assign w_duty_prod = DUTY_PW'(r_b_acc) * DUTY_PW'(DUTY_K);

    // ------------------------------------------------------------------
    // Stage C
    // ------------------------------------------------------------------
    logic [QW-1:0]     r_c_q;
    logic [PAIR_W-1:0] r_c_lo;
    logic [Q2W-1:0]    r_c_q2;
    logic [Q3W-1:0]    r_c_q3;
    logic [DUTY_W-1:0] r_c_duty;

    always_ff @(posedge i_clk) begin
        if (w_adv_b) begin
            r_c_q    <= r_b_q;
            r_c_lo   <= w_lo_full[PAIR_W-1:0];
            r_c_q2   <= w_q2_prod[Q2_SH +: Q2W];
            r_c_q3   <= w_q3_prod[Q3_SH +: Q3W];
            r_c_duty <= w_duty_prod[DUTY_SH +: DUTY_W];
        end
    end

    // digit split (stage C -> output)
    logic [DW-1:0]  w_mid_full;
    logic [TDW-1:0] w_tenk_full;
    t_digit_pair    w_lo_pair;
    t_digit_pair    w_mid_pair;

    assign w_mid_full  = DW'(r_c_q) - DW'(r_c_q2) * DW'(DIV_PAIR);
    assign w_tenk_full = TDW'(r_c_q2) - TDW'(r_c_q3) * TDW'(DIV_TEN);
    assign w_lo_pair   = f_split_pair(r_c_lo);
    assign w_mid_pair  = f_split_pair(w_mid_full[PAIR_W-1:0]);

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [DUTY_W-1:0]  r_out_duty;
    logic [TENK_W-1:0]  r_out_tenk;
    logic [DIGIT_W-1:0] r_out_thou;
    logic [DIGIT_W-1:0] r_out_hund;
    logic [DIGIT_W-1:0] r_out_tens;
    logic [DIGIT_W-1:0] r_out_ones;

    always_ff @(posedge i_clk) begin
        if (w_adv_c) begin
            r_out_duty <= r_c_duty;
            r_out_tenk <= w_tenk_full[TENK_W-1:0];
            r_out_thou <= w_mid_pair.tens;
            r_out_hund <= w_mid_pair.ones;
            r_out_tens <= w_lo_pair.tens;
            r_out_ones <= w_lo_pair.ones;
        end
    end

    assign o_duty                = r_out_duty;
    assign o_digit_ten_thousands = r_out_tenk;
    assign o_digit_thousands     = r_out_thou;
    assign o_digit_hundreds      = r_out_hund;
    assign o_digit_tens          = r_out_tens;
    assign o_digit_ones          = r_out_ones;

endmodule

### design/phpl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phpl_checker - port-level checks for the PID heater PWM loop
// Stall behavior, pipeline latency and digit ranges seen at the top level.
// ----------------------------------------------------------------------------
module phpl_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [phpl_pkg::DUTY_W-1:0]  o_duty,
    input logic [phpl_pkg::TENK_W-1:0]  o_digit_ten_thousands,
    input logic [phpl_pkg::DIGIT_W-1:0] o_digit_thousands,
    input logic [phpl_pkg::DIGIT_W-1:0] o_digit_hundreds,
    input logic [phpl_pkg::DIGIT_W-1:0] o_digit_tens,
    input logic [phpl_pkg::DIGIT_W-1:0] o_digit_ones
);
    import phpl_pkg::*;

    // a waiting result word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_duty)
            && $stable(o_digit_ten_thousands) && $stable(o_digit_thousands)
            && $stable(o_digit_hundreds) && $stable(o_digit_tens)
            && $stable(o_digit_ones))
        else $error("result word changed while stalled");

    // an empty output register never back-pressures the input
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output");

    // an accepted word reaches the output when no stall comes on the way
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall ##1 !o_stall ##1 !o_stall ##1 !o_stall |=> o_valid)
        else $error("accepted sample did not reach the output in time");

    // decimal digits stay decimal
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_digit_thousands <= DIGIT_W'(DIGIT_MAX)
            && o_digit_hundreds <= DIGIT_W'(DIGIT_MAX)
            && o_digit_tens <= DIGIT_W'(DIGIT_MAX)
            && o_digit_ones <= DIGIT_W'(DIGIT_MAX))
        else $error("decimal digit out of range");

endmodule

bind pid_heater_pwm_loop phpl_checker u_phpl_checker (.*);
